FILE: rtl/clc_pkg.sv
// shared constants, word types and the linearisation table of the luminance block
package clc_pkg;

  // fixed-point formats
  localparam int FRAC_BITS = 16;
  localparam int Q_BITS    = 30;
  localparam int OUT_W     = FRAC_BITS + 1;
  localparam int LIN_W     = Q_BITS + 1;
  localparam int ACC_W     = Q_BITS + 1;
  localparam int CH_W      = 8;
  localparam int TAB_DEPTH = 1 << CH_W;

  // quotient bits of the contrast division and width of its numerator
  localparam int QB    = FRAC_BITS + 1;
  localparam int NUM_W = ACC_W + FRAC_BITS;

  // 0.05 in Q1.30
  localparam logic [ACC_W-1:0] OFFSET_Q = 31'd53687091;

  // queue between front and back
  localparam int QDEPTH   = 8;
  localparam int CREDIT_W = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_BLUE  = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } in_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] fg_luminance;
    logic [OUT_W-1:0] contrast_fraction;
    logic             fg_brighter;
  } out_word_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [ACC_W-1:0] dark_sum;
    logic [ACC_W-1:0] bright_sum;
    logic [OUT_W-1:0] lum;
    logic             brighter;
  } q_word_t;

  typedef logic [TAB_DEPTH-1:0][LIN_W-1:0] lin_tab_t;

  // one linearised channel in Q1.30, evaluated at elaboration only
  function automatic logic [LIN_W-1:0] lin_entry(input longint unsigned v);
    longint unsigned one;
    longint unsigned t;
    longint unsigned s;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned p;
    longint unsigned res;
    one = 64'd1 << Q_BITS;
    if (v <= 64'd10) begin
      res = (64'd10 * v * one) / 64'd32946;
    end else begin
      t  = ((64'd1000 * v + 64'd14025) * one) / 64'd269025;
      s  = (t * t) >> Q_BITS;
      lo = 64'd0;
      hi = one;
      // largest r with r^5 <= s, so that s * r is t to the power 2.4
      for (int i = 0; i < Q_BITS + 2; i++) begin
        if (lo < hi) begin
          mid = lo + ((hi - lo + 64'd1) >> 1);
          p   = mid;
          for (int k = 0; k < 4; k++) begin
            p = (p * mid) >> Q_BITS;
          end
          if (p <= s) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
      end
      res = (s * lo) >> Q_BITS;
    end
    return res[LIN_W-1:0];
  endfunction

  function automatic lin_tab_t build_lin_table();
    lin_tab_t tab;
    for (int v = 0; v < TAB_DEPTH; v++) begin
      tab[v] = lin_entry(longint'(v));
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TABLE = build_lin_table();

endpackage

FILE: rtl/clc_fifo.sv
// small flop queue between the classifying front and the dividing back
module clc_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  clc_pkg::q_word_t  push_word_i,
  input  logic              pop_i,
  output logic              head_valid_o,
  output clc_pkg::q_word_t  head_word_o
);

  localparam int PTR_W = $clog2(clc_pkg::QDEPTH);
  localparam int CNT_W = $clog2(clc_pkg::QDEPTH + 1);

  clc_pkg::q_word_t mem_q [clc_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(clc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(clc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  assign head_valid_o = (count_q != '0);
  assign head_word_o  = mem_q[rd_ptr_q];

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q < CNT_W'(clc_pkg::QDEPTH))
    else $error("queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue read while empty");
`endif

endmodule

FILE: rtl/clc_front.sv
// front: configuration, table lookup, luminance sums and classification of each word
module clc_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [clc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [clc_pkg::CH_W-1:0]        cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  clc_pkg::in_word_t               in_word_i,
  input  logic                            pop_i,
  output logic                            push_valid_o,
  output clc_pkg::q_word_t                push_word_o
);

  // lane 0 carries the foreground, lane 1 the background
  localparam int LANES  = 2;
  localparam int CHANS  = 3;
  localparam int STAGES = 5;
  localparam int WGT_W  = 13;
  localparam int SUM_W  = 44;
  localparam int DIV_SH = 4;
  localparam int Y_W    = SUM_W - DIV_SH;
  localparam int SPLIT  = 20;
  localparam int PROD_W = 51;
  localparam int REM_W  = 11;
  localparam int LUM_SHIFT = clc_pkg::Q_BITS - clc_pkg::FRAC_BITS;

  localparam logic [WGT_W-1:0]  W_RED    = 13'd2126;
  localparam logic [WGT_W-1:0]  W_GREEN  = 13'd7152;
  localparam logic [WGT_W-1:0]  W_BLUE   = 13'd722;
  // floor(2^40 / 625); sum/10000 is (sum/16)/625
  localparam logic [PROD_W-1:0] RECIP    = 51'd1759218604;
  localparam logic [REM_W-1:0]  DIV_LOW  = 11'd625;
  localparam logic [clc_pkg::ACC_W-1:0] HALF_LSB = clc_pkg::ACC_W'(1) << (LUM_SHIFT - 1);

  logic [clc_pkg::CH_W-1:0] bg_red_q, bg_green_q, bg_blue_q;
  logic [clc_pkg::CREDIT_W-1:0] credit_q, credit_d;
  logic accept;

  logic [STAGES-1:0] vld_q;

  logic [clc_pkg::CH_W-1:0]  chan   [LANES][CHANS];
  logic [clc_pkg::LIN_W-1:0] lin_d  [LANES][CHANS];
  logic [clc_pkg::LIN_W-1:0] lin_q  [LANES][CHANS];
  logic [SUM_W-1:0]          sum_d  [LANES];
  logic [Y_W-1:0]            y_q    [LANES];
  logic [PROD_W-1:0]         ph_q   [LANES];
  logic [PROD_W-1:0]         pl_q   [LANES];
  logic [REM_W-1:0]          ylo3_q [LANES];
  logic [PROD_W:0]           qsum_d [LANES];
  logic [clc_pkg::LIN_W-1:0] qe_q   [LANES];
  logic [REM_W-1:0]          ylo4_q [LANES];
  logic [REM_W-1:0]          rem_d  [LANES];
  logic [clc_pkg::LIN_W-1:0] lum_d  [LANES];
  logic [clc_pkg::LIN_W-1:0] lum_q  [LANES];

  logic                      brighter;
  logic [clc_pkg::ACC_W-1:0] round_sum;
  clc_pkg::q_word_t          cls_d, cls_q;
  logic                      cls_vld_q;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_red_q   <= '0;
      bg_green_q <= '0;
      bg_blue_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        clc_pkg::CFG_BG_RED:   bg_red_q   <= cfg_data_i;
        clc_pkg::CFG_BG_GREEN: bg_green_q <= cfg_data_i;
        clc_pkg::CFG_BG_BLUE:  bg_blue_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // credit covers words in flight here and words waiting in the queue
  assign in_ready_o = (credit_q < clc_pkg::CREDIT_W'(clc_pkg::QDEPTH));
  assign accept     = in_valid_i && in_ready_o;
  assign credit_d   = credit_q + clc_pkg::CREDIT_W'(accept) - clc_pkg::CREDIT_W'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q  <= '0;
      vld_q     <= '0;
      cls_vld_q <= 1'b0;
    end else begin
      credit_q  <= credit_d;
      vld_q     <= {vld_q[STAGES-2:0], accept};
      cls_vld_q <= vld_q[STAGES-1];
    end
  end

  // table lookup and weighted sums
  always_comb begin
    chan[0][0] = in_word_i.red;
    chan[0][1] = in_word_i.green;
    chan[0][2] = in_word_i.blue;
    chan[1][0] = bg_red_q;
    chan[1][1] = bg_green_q;
    chan[1][2] = bg_blue_q;
    for (int l = 0; l < LANES; l++) begin
      for (int c = 0; c < CHANS; c++) begin
        lin_d[l][c] = clc_pkg::LIN_TABLE[chan[l][c]];
      end
      sum_d[l] = SUM_W'(W_RED) * SUM_W'(lin_q[l][0])
               + SUM_W'(W_GREEN) * SUM_W'(lin_q[l][1])
               + SUM_W'(W_BLUE) * SUM_W'(lin_q[l][2]);
    end
  end

  // reciprocal estimate and its correction
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qsum_d[l] = (PROD_W + 1)'(ph_q[l]) + (PROD_W + 1)'(pl_q[l] >> SPLIT);
      rem_d[l]  = ylo4_q[l] - REM_W'(qe_q[l][REM_W-1:0] * DIV_LOW);
      lum_d[l]  = qe_q[l] + clc_pkg::LIN_W'(rem_d[l] >= DIV_LOW);
    end
  end

  // lane registers run every cycle; the background lane follows the registers
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      for (int c = 0; c < CHANS; c++) begin
        lin_q[l][c] <= lin_d[l][c];
      end
      y_q[l]    <= sum_d[l][SUM_W-1:DIV_SH];
      ph_q[l]   <= PROD_W'(y_q[l][Y_W-1:SPLIT]) * RECIP;
      pl_q[l]   <= PROD_W'(y_q[l][SPLIT-1:0]) * RECIP;
      ylo3_q[l] <= y_q[l][REM_W-1:0];
      qe_q[l]   <= qsum_d[l][SPLIT +: clc_pkg::LIN_W];
      ylo4_q[l] <= ylo3_q[l];
      lum_q[l]  <= lum_d[l];
    end
  end

  // classification: order the two luminances, add the offset and round the foreground luminance
  always_comb begin
    brighter           = lum_q[0] > lum_q[1];
    round_sum          = lum_q[0] + HALF_LSB;
    cls_d.brighter     = brighter;
    cls_d.dark_sum     = (brighter ? lum_q[1] : lum_q[0]) + clc_pkg::OFFSET_Q;
    cls_d.bright_sum   = (brighter ? lum_q[0] : lum_q[1]) + clc_pkg::OFFSET_Q;
    cls_d.lum          = round_sum[clc_pkg::ACC_W-1:LUM_SHIFT];
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
  end

  assign push_valid_o = cls_vld_q;
  assign push_word_o  = cls_q;

`ifndef SYNTHESIS
  a_credit_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= clc_pkg::CREDIT_W'(clc_pkg::QDEPTH))
    else $error("credit count beyond queue depth");

  a_push_counted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o |-> credit_q != '0)
    else $error("word pushed without a credit held");
`endif

endmodule

FILE: rtl/clc_back.sv
// back: pipelined restoring division for the contrast fraction and the output stage
module clc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  clc_pkg::q_word_t  head_word_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output clc_pkg::out_word_t out_word_o
);

  localparam int QB    = clc_pkg::QB;
  localparam int ACC_W = clc_pkg::ACC_W;

  logic en;
  logic [clc_pkg::NUM_W-1:0] num;

  logic [QB-1:0]    vld_q;
  logic [ACC_W-1:0] rem_q [QB];
  logic [QB-1:0]    low_q [QB];
  logic [QB-1:0]    quo_q [QB];
  logic [ACC_W-1:0] den_q [QB];
  logic [clc_pkg::OUT_W-1:0] lum_q [QB];
  logic             brt_q [QB];

  logic [ACC_W-1:0] rem_in [QB];
  logic [QB-1:0]    low_in [QB];
  logic [QB-1:0]    quo_in [QB];
  logic [ACC_W-1:0] den_in [QB];
  logic [ACC_W:0]   trial  [QB];
  logic             ge     [QB];
  logic [ACC_W-1:0] rem_d  [QB];
  logic [QB-1:0]    low_d  [QB];
  logic [QB-1:0]    quo_d  [QB];

  // whole back pipeline moves when the output stage is free or being taken
  assign en    = !vld_q[QB-1] || out_ready_i;
  assign pop_o = en && head_valid_i;

  // numerator a * 2^F + floor(b / 2); its top bits start the remainder
  assign num = (clc_pkg::NUM_W'(head_word_i.dark_sum) << clc_pkg::FRAC_BITS)
             + clc_pkg::NUM_W'(head_word_i.bright_sum >> 1);

  // one quotient bit per stage
  always_comb begin
    for (int k = 0; k < QB; k++) begin
      if (k == 0) begin
        rem_in[k] = ACC_W'(num[clc_pkg::NUM_W-1:QB]);
        low_in[k] = num[QB-1:0];
        quo_in[k] = '0;
        den_in[k] = head_word_i.bright_sum;
      end else begin
        rem_in[k] = rem_q[k-1];
        low_in[k] = low_q[k-1];
        quo_in[k] = quo_q[k-1];
        den_in[k] = den_q[k-1];
      end
      trial[k] = {rem_in[k], low_in[k][QB-1]};
      ge[k]    = trial[k] >= {1'b0, den_in[k]};
      rem_d[k] = ge[k] ? ACC_W'(trial[k] - {1'b0, den_in[k]}) : trial[k][ACC_W-1:0];
      low_d[k] = low_in[k] << 1;
      quo_d[k] = {quo_in[k][QB-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[QB-2:0], head_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < QB; k++) begin
        rem_q[k] <= rem_d[k];
        low_q[k] <= low_d[k];
        quo_q[k] <= quo_d[k];
        den_q[k] <= den_in[k];
        if (k == 0) begin
          lum_q[k] <= head_word_i.lum;
          brt_q[k] <= head_word_i.brighter;
        end else begin
          lum_q[k] <= lum_q[k-1];
          brt_q[k] <= brt_q[k-1];
        end
      end
    end
  end

  // last stage is the output register
  assign out_valid_o                  = vld_q[QB-1];
  assign out_word_o.fg_luminance      = lum_q[QB-1];
  assign out_word_o.contrast_fraction = quo_q[QB-1];
  assign out_word_o.fg_brighter       = brt_q[QB-1];

`ifndef SYNTHESIS
  a_fraction_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.contrast_fraction <=
      (clc_pkg::OUT_W'(1) << clc_pkg::FRAC_BITS))
    else $error("contrast fraction above one");

  a_divisor_offset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> den_q[0] >= clc_pkg::OFFSET_Q)
    else $error("divisor lost its offset");
`endif

endmodule

FILE: rtl/color_luminance_contrast.sv
// top level of the colour luminance and contrast block
//
//   channel   direction  handshake                     word
//   cfg       in         cfg_valid_i / cfg_ready_o     cfg_index_i, cfg_data_i
//   in        in         in_valid_i / in_ready_o       in_word_i (red, green, blue)
//   out       out        out_valid_o / out_ready_i     out_word_o (luminance, fraction, flag)
//
// one word per cycle sustained while the output is taken; the path from input to output is:
// six front stages, one queue slot, then one divider stage per quotient bit
// the front takes a word while it holds a credit; eight credits cover the front and queue
// the back stalls as a whole when the output stage is held; the front keeps filling the queue
// reset clears the background registers, credits, queue pointers and stage valid bits
// configuration is always ready and takes effect for words accepted after the write
module color_luminance_contrast (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [clc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [clc_pkg::CH_W-1:0]       cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  clc_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output clc_pkg::out_word_t             out_word_o
);

  logic             push_valid;
  clc_pkg::q_word_t push_word;
  logic             pop;
  logic             head_valid;
  clc_pkg::q_word_t head_word;

  // classification front
  clc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .pop_i        (pop),
    .push_valid_o (push_valid),
    .push_word_o  (push_word)
  );

  // decoupling queue
  clc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_word_i  (push_word),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_word_o  (head_word)
  );

  // division back end
  clc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_word_i  (head_word),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o)
  );

endmodule
